### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by wfr_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define WFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfr assertion failed");

// next-cycle implication, disabled in reset
`define WFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfr assertion failed");

`endif

### hdl/wfr_pkg.sv
// ----------------------------------------------------------------------------
// wfr_pkg
// Types and constants of the WebSocket frame receiver.
// ----------------------------------------------------------------------------
package wfr_pkg;

  localparam int unsigned CAP_W = 24;
  localparam int unsigned LEN_W = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 24'd4096;

  // config register indexes
  localparam logic [0:0] CFG_CLIENT_ROLE = 1'b0;
  localparam logic [0:0] CFG_MSG_CAP     = 1'b1;

  // input opcodes
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_LOCAL   = 1'b1;

  // frame header fields
  localparam logic [7:0] RSV_MASK   = 8'h70;
  localparam logic [3:0] FOP_CLOSE  = 4'h8;
  localparam logic [3:0] FOP_PING   = 4'h9;
  localparam logic [3:0] FOP_PONG   = 4'ha;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_CNT  = 3'd1;
  localparam logic [2:0] EXT64_CNT  = 3'd7;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_END     = 3'd1,
    KIND_PING    = 3'd2,
    KIND_PONG    = 3'd3,
    KIND_CLOSE   = 3'd4,
    KIND_ERROR   = 3'd5,
    KIND_LOCAL   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    REPLY_NONE  = 2'd0,
    REPLY_PONG  = 2'd1,
    REPLY_CLOSE = 2'd2
  } reply_t;

  typedef enum logic [4:0] {
    PH_HDR1    = 5'b00001,
    PH_HDR2    = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] message_length;
    reply_t           reply;
  } result_t;

endpackage

### hdl/wfr_in_stage.sv
// ----------------------------------------------------------------------------
// wfr_in_stage
// Input register; holds one beat until the parser takes it.
// ----------------------------------------------------------------------------
module wfr_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_opcode,
  input  logic [7:0]     in_rx_byte,
  input  logic           take,
  output logic           item_valid,
  output wfr_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  wfr_pkg::item_t item_r;
  logic           load;

  assign in_stall  = valid_r & ~take;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.opcode  <= in_opcode;
      item_r.rx_byte <= in_rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### hdl/wfr_parser.sv
// ----------------------------------------------------------------------------
// wfr_parser
// Frame parser: header, extended length, mask key and payload handling,
// configuration registers and per-beat result generation.
// ----------------------------------------------------------------------------
module wfr_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [wfr_pkg::CAP_W-1:0] cfg_data,
  input  logic                      item_valid,
  input  wfr_pkg::item_t            item,
  input  logic                      out_free,
  output logic                      take,
  output logic                      res_load,
  output wfr_pkg::result_t          res
);

  // configuration
  logic                      client_r;
  logic [wfr_pkg::CAP_W-1:0] capacity_r;

  // parser state
  wfr_pkg::phase_t           phase_r,    phase_nxt;
  logic                      fin_r,      fin_nxt;
  logic [3:0]                fop_r,      fop_nxt;
  logic [2:0]                ext_cnt_r,  ext_cnt_nxt;
  logic [wfr_pkg::LEN_W-1:0] remain_r,   remain_nxt;
  logic [1:0]                fidx_r,     fidx_nxt;
  logic [31:0]               mkey_r,     mkey_nxt;
  logic [wfr_pkg::CAP_W-1:0] cap_left_r, cap_left_nxt;
  logic [wfr_pkg::LEN_W-1:0] total_r,    total_nxt;
  logic                      ldone_r,    ldone_nxt;
  logic                      broken_r,   broken_nxt;
  logic                      in_msg_r,   in_msg_nxt;

  logic                      res_vld;
  wfr_pkg::result_t          res_c;
  logic [7:0]                b;
  logic [6:0]                len7;
  logic                      is_ctl;
  logic                      go_len;
  logic                      len_known;
  logic                      hdr_done;
  logic                      ends;
  logic [7:0]                key_byte;
  logic [wfr_pkg::LEN_W-1:0] rem_dec;
  logic [wfr_pkg::LEN_W:0]   sum;

  assign b      = item.rx_byte;
  assign len7   = b[6:0];
  assign is_ctl = (fop_r == wfr_pkg::FOP_CLOSE) || (fop_r == wfr_pkg::FOP_PING) ||
                  (fop_r == wfr_pkg::FOP_PONG);
  assign rem_dec = remain_r - {{(wfr_pkg::LEN_W-1){1'b0}}, 1'b1};

  always_comb begin
    unique case (fidx_r)
      2'd0:    key_byte = mkey_r[31:24];
      2'd1:    key_byte = mkey_r[23:16];
      2'd2:    key_byte = mkey_r[15:8];
      default: key_byte = mkey_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    fin_nxt      = fin_r;
    fop_nxt      = fop_r;
    ext_cnt_nxt  = ext_cnt_r;
    remain_nxt   = remain_r;
    fidx_nxt     = fidx_r;
    mkey_nxt     = mkey_r;
    cap_left_nxt = cap_left_r;
    total_nxt    = total_r;
    ldone_nxt    = ldone_r;
    broken_nxt   = broken_r;
    in_msg_nxt   = in_msg_r;
    res_vld      = 1'b0;
    res_c        = '0;
    go_len       = 1'b0;
    len_known    = 1'b0;
    hdr_done     = 1'b0;
    ends         = 1'b0;
    sum          = '0;

    if (item.opcode == wfr_pkg::OP_LOCAL) begin
      res_vld    = 1'b1;
      res_c.kind = wfr_pkg::KIND_LOCAL;
      if (!broken_r && !ldone_r) begin
        ldone_nxt   = 1'b1;
        res_c.reply = wfr_pkg::REPLY_CLOSE;
      end
    end else if (!broken_r) begin
      unique case (phase_r)
        wfr_pkg::PH_HDR1: begin
          if ((b & wfr_pkg::RSV_MASK) != 8'h00) begin
            broken_nxt = 1'b1;
            res_vld    = 1'b1;
            res_c.kind = wfr_pkg::KIND_ERROR;
          end else begin
            fin_nxt   = b[7];
            fop_nxt   = b[3:0];
            phase_nxt = wfr_pkg::PH_HDR2;
          end
        end
        wfr_pkg::PH_HDR2: begin
          go_len = 1'b1;
          if (is_ctl) begin
            res_vld = 1'b1;
            if (fop_r == wfr_pkg::FOP_CLOSE) begin
              broken_nxt  = 1'b1;
              ldone_nxt   = 1'b1;
              phase_nxt   = wfr_pkg::PH_HDR1;
              res_c.kind  = wfr_pkg::KIND_CLOSE;
              res_c.reply = ldone_r ? wfr_pkg::REPLY_NONE : wfr_pkg::REPLY_CLOSE;
              go_len      = 1'b0;
            end else if (fop_r == wfr_pkg::FOP_PING) begin
              res_c.kind  = wfr_pkg::KIND_PING;
              res_c.reply = ldone_r ? wfr_pkg::REPLY_NONE : wfr_pkg::REPLY_PONG;
            end else begin
              res_c.kind  = wfr_pkg::KIND_PONG;
            end
          end else if (client_r == b[7]) begin
            broken_nxt = 1'b1;
            res_vld    = 1'b1;
            res_c.kind = wfr_pkg::KIND_ERROR;
            go_len     = 1'b0;
          end else if (!in_msg_r) begin
            in_msg_nxt   = 1'b1;
            cap_left_nxt = capacity_r;
            total_nxt    = '0;
          end
          if (go_len) begin
            if (len7 == wfr_pkg::LEN7_EXT16 || len7 == wfr_pkg::LEN7_EXT64) begin
              ext_cnt_nxt = (len7 == wfr_pkg::LEN7_EXT16) ? wfr_pkg::EXT16_CNT
                                                          : wfr_pkg::EXT64_CNT;
              remain_nxt  = '0;
              phase_nxt   = wfr_pkg::PH_EXT;
            end else begin
              remain_nxt = {{(wfr_pkg::LEN_W-7){1'b0}}, len7};
              len_known  = 1'b1;
            end
          end
        end
        wfr_pkg::PH_EXT: begin
          remain_nxt = {remain_r[wfr_pkg::LEN_W-9:0], b};
          if (ext_cnt_r == 3'd0) begin
            len_known = 1'b1;
          end else begin
            ext_cnt_nxt = ext_cnt_r - 3'd1;
          end
        end
        wfr_pkg::PH_MASK: begin
          mkey_nxt = {mkey_r[23:0], b};
          if (fidx_r == 2'd3) begin
            hdr_done = 1'b1;
          end else begin
            fidx_nxt = fidx_r + 2'd1;
          end
        end
        wfr_pkg::PH_PAYLOAD: begin
          remain_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = wfr_pkg::PH_HDR1;
          end
          if (!is_ctl) begin
            ends = (rem_dec == '0) && fin_r;
            if (ends) begin
              in_msg_nxt = 1'b0;
            end
            fidx_nxt = fidx_r + 2'd1;
            if (cap_left_r != '0) begin
              cap_left_nxt         = cap_left_r - {{(wfr_pkg::CAP_W-1){1'b0}}, 1'b1};
              res_vld              = 1'b1;
              res_c.kind           = wfr_pkg::KIND_PAYLOAD;
              res_c.data           = client_r ? b : (b ^ key_byte);
              res_c.last           = ends;
              res_c.message_length = ends ? total_r : '0;
            end else if (ends) begin
              res_vld              = 1'b1;
              res_c.kind           = wfr_pkg::KIND_END;
              res_c.message_length = total_r;
            end
          end
        end
        default: begin
          phase_nxt = wfr_pkg::PH_HDR1;
        end
      endcase

      if (len_known) begin
        if (!client_r) begin
          phase_nxt = wfr_pkg::PH_MASK;
          fidx_nxt  = 2'd0;
          mkey_nxt  = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        if (is_ctl) begin
          phase_nxt = (remain_nxt == '0) ? wfr_pkg::PH_HDR1 : wfr_pkg::PH_PAYLOAD;
        end else begin
          sum       = {1'b0, total_nxt} + {1'b0, remain_nxt};
          total_nxt = sum[wfr_pkg::LEN_W] ? '1 : sum[wfr_pkg::LEN_W-1:0];
          if (remain_nxt == '0) begin
            phase_nxt = wfr_pkg::PH_HDR1;
            if (fin_r) begin
              in_msg_nxt           = 1'b0;
              res_vld              = 1'b1;
              res_c.kind           = wfr_pkg::KIND_END;
              res_c.message_length = total_nxt;
            end
          end else begin
            phase_nxt = wfr_pkg::PH_PAYLOAD;
            fidx_nxt  = 2'd0;
          end
        end
      end
    end
  end

  assign take     = item_valid & (~res_vld | out_free);
  assign res_load = take & res_vld;
  assign res      = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_r   <= 1'b0;
      capacity_r <= wfr_pkg::CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == wfr_pkg::CFG_CLIENT_ROLE) begin
        client_r <= cfg_data[0];
      end
      if (cfg_index == wfr_pkg::CFG_MSG_CAP) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wfr_pkg::PH_HDR1;
      fin_r      <= 1'b0;
      fop_r      <= '0;
      ext_cnt_r  <= '0;
      remain_r   <= '0;
      fidx_r     <= '0;
      mkey_r     <= '0;
      cap_left_r <= '0;
      total_r    <= '0;
      ldone_r    <= 1'b0;
      broken_r   <= 1'b0;
      in_msg_r   <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      fin_r      <= fin_nxt;
      fop_r      <= fop_nxt;
      ext_cnt_r  <= ext_cnt_nxt;
      remain_r   <= remain_nxt;
      fidx_r     <= fidx_nxt;
      mkey_r     <= mkey_nxt;
      cap_left_r <= cap_left_nxt;
      total_r    <= total_nxt;
      ldone_r    <= ldone_nxt;
      broken_r   <= broken_nxt;
      in_msg_r   <= in_msg_nxt;
    end
  end

endmodule

### hdl/wfr_out_stage.sv
// ----------------------------------------------------------------------------
// wfr_out_stage
// Result register; holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module wfr_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      res_load,
  input  wfr_pkg::result_t          res,
  output logic                      out_free,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_kind,
  output logic [7:0]                out_data,
  output logic                      out_last,
  output logic [wfr_pkg::LEN_W-1:0] out_message_length,
  output logic [1:0]                out_reply
);

  logic             valid_r;
  logic             valid_nxt;
  wfr_pkg::result_t res_r;

  assign out_free  = ~valid_r | ~out_stall;
  assign valid_nxt = res_load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = res_r.kind;
  assign out_data           = res_r.data;
  assign out_last           = res_r.last;
  assign out_message_length = res_r.message_length;
  assign out_reply          = res_r.reply;

endmodule

### hdl/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Path: an accepted beat is held in the input register, then passes through the
// parser logic into the result register, which drives the out ports.
// Throughput: one beat per cycle; only a stalled result register holds input.
// Reset: synchronous; parser state, sticky flags and valids clear, client_role
// returns to 0 and message_capacity to 4096.
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [wfr_pkg::CAP_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_kind,
  output logic [7:0]                out_data,
  output logic                      out_last,
  output logic [wfr_pkg::LEN_W-1:0] out_message_length,
  output logic [1:0]                out_reply
);

  logic             take;
  logic             item_valid;
  wfr_pkg::item_t   item;
  logic             out_free;
  logic             res_load;
  wfr_pkg::result_t res;

  wfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  wfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  wfr_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_load           (res_load),
    .res                (res),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data           (out_data),
    .out_last           (out_last),
    .out_message_length (out_message_length),
    .out_reply          (out_reply)
  );

endmodule

### hdl/wfr_checker.sv
// ----------------------------------------------------------------------------
// wfr_checker
// Port-level checks of the frame receiver result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wfr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [2:0]                out_kind,
  input logic [7:0]                out_data,
  input logic                      out_last,
  input logic [wfr_pkg::LEN_W-1:0] out_message_length,
  input logic [1:0]                out_reply
);

  `WFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_data) && $stable(out_last) && $stable(out_message_length) && $stable(out_reply))
  `WFR_ASSERT_SAME(a_last_is_payload, clk, rst_n, out_valid && out_last, out_kind == wfr_pkg::KIND_PAYLOAD)
  `WFR_ASSERT_SAME(a_data_only_payload, clk, rst_n, out_valid && out_kind != wfr_pkg::KIND_PAYLOAD, out_data == 8'h00)
  `WFR_ASSERT_SAME(a_pong_reply_on_ping, clk, rst_n, out_valid && out_reply == wfr_pkg::REPLY_PONG, out_kind == wfr_pkg::KIND_PING)
  `WFR_ASSERT_SAME(a_close_reply_src, clk, rst_n, out_valid && out_reply == wfr_pkg::REPLY_CLOSE, out_kind == wfr_pkg::KIND_CLOSE || out_kind == wfr_pkg::KIND_LOCAL)

endmodule

bind websocket_frame_receiver wfr_checker u_wfr_checker (.*);

### test/wfr_event_checker.sv
// ----------------------------------------------------------------------------
// wfr_event_checker
// Watches the beats into and out of the WebSocket frame receiver. Each
// accepted input beat is run through a parser model held here, and every
// result beat is compared field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module wfr_event_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [wfr_pkg::CAP_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [7:0]                in_rx_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [2:0]                out_kind,
  input  logic [7:0]                out_data,
  input  logic                      out_last,
  input  logic [wfr_pkg::LEN_W-1:0] out_message_length,
  input  logic [1:0]                out_reply,
  output int                        fail_count,
  output int                        pending
);

  logic                      is_client;
  logic [wfr_pkg::CAP_W-1:0] msg_cap;
  wfr_pkg::phase_t           ph;
  logic                      fin;
  logic [3:0]                fop;
  logic [2:0]                ext_left;
  logic [wfr_pkg::LEN_W-1:0] remaining;
  logic [1:0]                key_pos;
  logic [31:0]               key;
  logic [wfr_pkg::CAP_W-1:0] cap_left;
  logic [wfr_pkg::LEN_W-1:0] msg_total;
  logic                      closed_local;
  logic                      dead;
  logic                      in_msg;
  wfr_pkg::result_t          due_events[$];

  function automatic wfr_pkg::result_t make_event(wfr_pkg::kind_t k, logic [7:0] d,
                                                  logic l,
                                                  logic [wfr_pkg::LEN_W-1:0] n,
                                                  wfr_pkg::reply_t r);
    wfr_pkg::result_t e;
    e.kind = k;
    e.data = d;
    e.last = l;
    e.message_length = n;
    e.reply = r;
    return e;
  endfunction

  function automatic bit is_ctrl();
    return fop == wfr_pkg::FOP_CLOSE || fop == wfr_pkg::FOP_PING ||
           fop == wfr_pkg::FOP_PONG;
  endfunction

  function automatic bit header_end(output wfr_pkg::result_t r);
    r = '0;
    if (is_ctrl()) begin
      ph = (remaining == 0) ? wfr_pkg::PH_HDR1 : wfr_pkg::PH_PAYLOAD;
      return 0;
    end
    if (msg_total > ~remaining) msg_total = '1;
    else msg_total = msg_total + remaining;
    if (remaining == 0) begin
      ph = wfr_pkg::PH_HDR1;
      if (fin) begin
        in_msg = 1'b0;
        r = make_event(wfr_pkg::KIND_END, 8'h00, 1'b0, msg_total, wfr_pkg::REPLY_NONE);
        return 1;
      end
      return 0;
    end
    ph = wfr_pkg::PH_PAYLOAD;
    key_pos = 2'd0;
    return 0;
  endfunction

  function automatic bit length_end(output wfr_pkg::result_t r);
    r = '0;
    if (!is_client) begin
      ph = wfr_pkg::PH_MASK;
      key_pos = 2'd0;
      key = '0;
      return 0;
    end
    return header_end(r);
  endfunction

  function automatic bit parse_beat(input logic op, input logic [7:0] b,
                                    output wfr_pkg::result_t r);
    logic [6:0]       len7;
    logic [7:0]       d;
    wfr_pkg::reply_t  rep;
    bit               hit;
    bit               ends;
    wfr_pkg::result_t spare;
    r = '0;
    hit = 0;
    len7 = b[6:0];
    if (op == wfr_pkg::OP_LOCAL) begin
      rep = wfr_pkg::REPLY_NONE;
      if (!dead && !closed_local) begin
        closed_local = 1'b1;
        rep = wfr_pkg::REPLY_CLOSE;
      end
      r = make_event(wfr_pkg::KIND_LOCAL, 8'h00, 1'b0, 64'd0, rep);
      return 1;
    end
    if (dead) return 0;
    case (ph)
      wfr_pkg::PH_HDR1: begin
        if ((b & wfr_pkg::RSV_MASK) != 0) begin
          dead = 1'b1;
          r = make_event(wfr_pkg::KIND_ERROR, 8'h00, 1'b0, 64'd0, wfr_pkg::REPLY_NONE);
          return 1;
        end
        fin = b[7];
        fop = b[3:0];
        ph = wfr_pkg::PH_HDR2;
      end
      wfr_pkg::PH_HDR2: begin
        if (is_ctrl()) begin
          rep = (closed_local || fop == wfr_pkg::FOP_PONG) ? wfr_pkg::REPLY_NONE :
                (fop == wfr_pkg::FOP_CLOSE) ? wfr_pkg::REPLY_CLOSE : wfr_pkg::REPLY_PONG;
          if (fop == wfr_pkg::FOP_CLOSE) begin
            dead = 1'b1;
            closed_local = 1'b1;
            ph = wfr_pkg::PH_HDR1;
            r = make_event(wfr_pkg::KIND_CLOSE, 8'h00, 1'b0, 64'd0, rep);
            return 1;
          end
          r = make_event((fop == wfr_pkg::FOP_PING) ? wfr_pkg::KIND_PING
                                                    : wfr_pkg::KIND_PONG,
                         8'h00, 1'b0, 64'd0, rep);
          hit = 1;
        end else begin
          if (is_client == b[7]) begin
            dead = 1'b1;
            r = make_event(wfr_pkg::KIND_ERROR, 8'h00, 1'b0, 64'd0, wfr_pkg::REPLY_NONE);
            return 1;
          end
          if (!in_msg) begin
            in_msg = 1'b1;
            cap_left = msg_cap;
            msg_total = '0;
          end
        end
        if (len7 == wfr_pkg::LEN7_EXT16 || len7 == wfr_pkg::LEN7_EXT64) begin
          ext_left = (len7 == wfr_pkg::LEN7_EXT16) ? wfr_pkg::EXT16_CNT
                                                   : wfr_pkg::EXT64_CNT;
          remaining = '0;
          ph = wfr_pkg::PH_EXT;
          return hit;
        end
        remaining = {{(wfr_pkg::LEN_W-7){1'b0}}, len7};
        if (hit) void'(length_end(spare));
        else hit = length_end(r);
        return hit;
      end
      wfr_pkg::PH_EXT: begin
        remaining = {remaining[wfr_pkg::LEN_W-9:0], b};
        if (ext_left == 0) return length_end(r);
        ext_left = ext_left - 3'd1;
      end
      wfr_pkg::PH_MASK: begin
        key = {key[23:0], b};
        if (key_pos == 2'd3) return header_end(r);
        key_pos = key_pos + 2'd1;
      end
      wfr_pkg::PH_PAYLOAD: begin
        remaining = remaining - 1'b1;
        if (remaining == 0) ph = wfr_pkg::PH_HDR1;
        if (is_ctrl()) return 0;
        ends = (remaining == 0) && fin;
        if (ends) in_msg = 1'b0;
        d = b;
        if (!is_client) d = b ^ key[8*(3-key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        if (cap_left > 0) begin
          cap_left = cap_left - 1'b1;
          r = make_event(wfr_pkg::KIND_PAYLOAD, d, ends, ends ? msg_total : 64'd0,
                         wfr_pkg::REPLY_NONE);
          return 1;
        end
        if (ends) begin
          r = make_event(wfr_pkg::KIND_END, 8'h00, 1'b0, msg_total, wfr_pkg::REPLY_NONE);
          return 1;
        end
      end
      default: ph = wfr_pkg::PH_HDR1;
    endcase
    return 0;
  endfunction

  task automatic report(input string what, input logic [wfr_pkg::LEN_W-1:0] got,
                        input logic [wfr_pkg::LEN_W-1:0] want);
    if (fail_count < 100)
      $display("%0t: bad %s: got %0h, expected %0h", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin : watch
    wfr_pkg::result_t want;
    if (!rst_n) begin
      is_client = 1'b0;
      msg_cap = wfr_pkg::CAP_RESET;
      ph = wfr_pkg::PH_HDR1;
      fin = 1'b0;
      fop = '0;
      ext_left = '0;
      remaining = '0;
      key_pos = '0;
      key = '0;
      cap_left = '0;
      msg_total = '0;
      closed_local = 1'b0;
      dead = 1'b0;
      in_msg = 1'b0;
      due_events.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == wfr_pkg::CFG_CLIENT_ROLE) is_client = cfg_data[0];
        else msg_cap = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0) begin
          report("beat with no event due, kind", 64'(out_kind), '0);
        end else begin
          want = due_events.pop_front();
          if (out_kind !== want.kind) report("kind", 64'(out_kind), 64'(want.kind));
          if (out_data !== want.data) report("data", 64'(out_data), 64'(want.data));
          if (out_last !== want.last) report("last", 64'(out_last), 64'(want.last));
          if (out_message_length !== want.message_length)
            report("message_length", out_message_length, want.message_length);
          if (out_reply !== want.reply) report("reply", 64'(out_reply), 64'(want.reply));
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_beat(in_opcode, in_rx_byte, want)) due_events.push_back(want);
      end
    end
    pending <= due_events.size();
  end

endmodule

### test/tb_websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_receiver
// Feeds the frame receiver with short directed frames, then with long runs of
// well-formed frames of random content under changing role and capacity,
// and ends with a frame that breaks the stream or one that never ends.
// Results are checked by wfr_event_checker.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BEATS = 1500;
  localparam int HOLD_CYCLES  = 300;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [0:0]                cfg_index = wfr_pkg::CFG_CLIENT_ROLE;
  logic [wfr_pkg::CAP_W-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_opcode = wfr_pkg::OP_RX_BYTE;
  logic [7:0]                in_rx_byte = 8'h00;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic [2:0]                out_kind;
  logic [7:0]                out_data;
  logic                      out_last;
  logic [wfr_pkg::LEN_W-1:0] out_message_length;
  logic [1:0]                out_reply;

  int fail_count;
  int pending;
  int cycles;
  int burst_left;
  int local_odds;
  int link_beats;
  bit no_gaps;
  bit hold_req;
  bit client_now;

  always #2 clk = ~clk;

  websocket_frame_receiver uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data           (out_data),
    .out_last           (out_last),
    .out_message_length (out_message_length),
    .out_reply          (out_reply)
  );

  wfr_event_checker frame_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data           (out_data),
    .out_last           (out_last),
    .out_message_length (out_message_length),
    .out_reply          (out_reply),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall density per stretch, plus one long hold-off
  initial begin : receiver
    int mode_left;
    int stall_pct;
    bit held;
    mode_left = 0;
    stall_pct = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  task automatic put_beat(input logic op, input logic [7:0] b);
    if (!no_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // sends the lowest n bytes of seq, most significant first
  task automatic send_bytes(input logic [127:0] seq, input int n);
    for (int i = n - 1; i >= 0; i--) put_beat(wfr_pkg::OP_RX_BYTE, seq[8*i +: 8]);
  endtask

  task automatic send_link(input logic [7:0] b);
    if (local_odds != 0 && $urandom_range(1, 1000) <= local_odds)
      put_beat(wfr_pkg::OP_LOCAL, 8'($urandom_range(0, 255)));
    put_beat(wfr_pkg::OP_RX_BYTE, b);
    link_beats++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input bit client, input logic [wfr_pkg::CAP_W-1:0] cap);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= wfr_pkg::CFG_CLIENT_ROLE;
    cfg_data <= {{(wfr_pkg::CAP_W-1){1'b0}}, client};
    @(posedge clk);
    cfg_index <= wfr_pkg::CFG_MSG_CAP;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    client_now = client;
  endtask

  // form: 0 shortest length encoding, 1 16-bit, 2 64-bit
  task automatic send_frame(input bit fin, input logic [3:0] fop,
                            input int unsigned len, input int form);
    logic [wfr_pkg::LEN_W-1:0] len64;
    logic mbit;
    len64 = 64'(len);
    if (fop == wfr_pkg::FOP_PING || fop == wfr_pkg::FOP_PONG || fop == wfr_pkg::FOP_CLOSE)
      mbit = 1'($urandom_range(0, 1));
    else mbit = !client_now;
    send_link({fin, 3'b000, fop});
    if (form == 0 && len < 126) begin
      send_link({mbit, len64[6:0]});
    end else if (form < 2 && len < 65536) begin
      send_link({mbit, wfr_pkg::LEN7_EXT16});
      send_link(len64[15:8]);
      send_link(len64[7:0]);
    end else begin
      send_link({mbit, wfr_pkg::LEN7_EXT64});
      for (int i = 7; i >= 0; i--) send_link(len64[8*i +: 8]);
    end
    if (!client_now) repeat (4) send_link(8'($urandom_range(0, 255)));
    repeat (len) send_link(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int next_cfg;
    int pick;
    int form;
    int unsigned len;
    bit first_cfg;
    logic [wfr_pkg::CAP_W-1:0] cap;
    logic [3:0] fop;
    next_cfg = 300;
    first_cfg = 1;
    client_now = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // server role, reset capacity: masked frame, key bytes all-ones and zero
    send_bytes(64'h81_82_ff_00_a5_5a_ff_00, 8);
    // client, no capacity: empty final frame, final frame with dropped bytes, ping, pong
    set_regs(1'b1, '0);
    send_bytes(48'h82_00_80_02_12_34, 6);
    send_bytes(40'h89_81_ab_8a_00, 5);
    // capacity 1 over a fragmented message: 16-bit then 64-bit length
    set_regs(1'b1, 24'd1);
    send_bytes(48'h01_7e_00_02_c3_3c, 6);
    send_bytes(88'h80_7f_00_00_00_00_00_00_00_01_ff, 11);
    // role switched between the two header bytes
    set_regs(1'b0, '1);
    send_bytes(8'h82, 1);
    set_regs(1'b1, '1);
    send_bytes(16'h01_5a, 2);

    link_beats = 0;
    while (link_beats < RANDOM_BEATS) begin
      if (link_beats > next_cfg) begin
        case ($urandom_range(0, 5))
          0: cap = '0;
          1: cap = 24'd1;
          2: cap = 24'($urandom_range(2, 24));
          3: cap = wfr_pkg::CAP_RESET;
          4: cap = '1;
          default: cap = 24'($urandom_range(0, 16777215));
        endcase
        if (first_cfg) cap = wfr_pkg::CAP_RESET;
        set_regs(1'($urandom_range(0, 1)), cap);
        if (first_cfg) hold_req = 1;
        first_cfg = 0;
        next_cfg += 300;
      end
      if (link_beats > RANDOM_BEATS / 2) local_odds = 3;
      if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        fop = $urandom_range(0, 1) ? wfr_pkg::FOP_PING : wfr_pkg::FOP_PONG;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 125) : $urandom_range(0, 4);
      end else begin
        pick = $urandom_range(0, 12);
        fop = (pick < 8) ? pick[3:0] : pick[3:0] + 4'd3;
        pick = $urandom_range(0, 99);
        if (pick < 50) len = $urandom_range(0, 8);
        else if (pick < 85) len = $urandom_range(9, 40);
        else if (pick < 97) len = $urandom_range(41, 125);
        else len = $urandom_range(126, 300);
      end
      pick = $urandom_range(0, 19);
      form = (pick < 2) ? 1 : (pick == 2) ? 2 : 0;
      send_frame($urandom_range(0, 3) != 0, fop, len, form);
    end

    // closing: one event that ends parsing for good, or an endless frame
    local_odds = 0;
    no_gaps = 0;
    case ($urandom_range(0, 3))
      0: begin
        pick = $urandom_range(1, 7);
        put_beat(wfr_pkg::OP_RX_BYTE,
                 {1'($urandom_range(0, 1)), pick[2:0], 4'($urandom_range(0, 15))});
      end
      1: begin
        put_beat(wfr_pkg::OP_RX_BYTE, {1'b1, 3'b000, 4'h2});
        put_beat(wfr_pkg::OP_RX_BYTE, {client_now, 7'd5});
      end
      2: begin
        if ($urandom_range(0, 1)) put_beat(wfr_pkg::OP_LOCAL, 8'($urandom_range(0, 255)));
        put_beat(wfr_pkg::OP_RX_BYTE, {1'b1, 3'b000, wfr_pkg::FOP_CLOSE});
        put_beat(wfr_pkg::OP_RX_BYTE, {1'($urandom_range(0, 1)), 7'd0});
      end
      default: begin
        put_beat(wfr_pkg::OP_RX_BYTE, {1'b1, 3'b000, 4'h2});
        put_beat(wfr_pkg::OP_RX_BYTE, {!client_now, wfr_pkg::LEN7_EXT64});
        repeat (8) put_beat(wfr_pkg::OP_RX_BYTE, 8'hff);
        if (!client_now)
          repeat (4) put_beat(wfr_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
        repeat (16) put_beat(wfr_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
      end
    endcase
    repeat (6) put_beat(wfr_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
    put_beat(wfr_pkg::OP_LOCAL, 8'($urandom_range(0, 255)));
    put_beat(wfr_pkg::OP_LOCAL, 8'($urandom_range(0, 255)));

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/wfr_pkg.sv
hdl/wfr_in_stage.sv
hdl/wfr_parser.sv
hdl/wfr_out_stage.sv
hdl/websocket_frame_receiver.sv
hdl/wfr_checker.sv
test/wfr_event_checker.sv
test/tb_websocket_frame_receiver.sv
